[rtl/wts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants of the waypoint trajectory sampler
// Item and result layouts, function and status codes, register indexes and
// the saturation helper used on velocity and acceleration.
// ----------------------------------------------------------------------------
package wts_pkg;

	// fixed field widths
	localparam int CoordBits = 32;
	localparam int TimeBits  = 32;
	localparam int CountBits = 9;
	localparam int IndexBits = 8;
	localparam int FracBits  = 16;
	localparam int RateBits  = 48;
	localparam int CfgBits   = 32;

	// function codes
	localparam logic FuncWrite = 1'b0;
	localparam logic FuncQuery = 1'b1;

	// status codes
	localparam logic [1:0] StatusOk    = 2'd0;
	localparam logic [1:0] StatusRange = 2'd1;
	localparam logic [1:0] StatusWrite = 2'd2;

	// register indexes
	localparam logic RegTotalTime  = 1'b0;
	localparam logic RegPointCount = 1'b1;

	typedef struct packed {
		logic                        func;
		logic [IndexBits-1:0]        point_index;
		logic signed [CoordBits-1:0] point_x;
		logic signed [CoordBits-1:0] point_y;
		logic [TimeBits-1:0]         query_time;
	} item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic signed [CoordBits-1:0] pos_x;
		logic signed [CoordBits-1:0] pos_y;
		logic signed [RateBits-1:0]  vel_x;
		logic signed [RateBits-1:0]  vel_y;
		logic signed [RateBits-1:0]  acc_x;
		logic signed [RateBits-1:0]  acc_y;
	} result_t;

	// one waypoint as stored in the table
	typedef struct packed {
		logic signed [CoordBits-1:0] x;
		logic signed [CoordBits-1:0] y;
	} wp_t;

	// the four waypoints around a segment
	typedef struct packed {
		wp_t prev;
		wp_t a;
		wp_t b;
		wp_t next;
	} taps_t;

	// signed saturating result from sign and magnitude quotient
	function automatic logic signed [RateBits-1:0] sat_rate(
		input logic                neg,
		input logic                ovf,
		input logic [RateBits-2:0] mag
	);
		logic signed [RateBits-1:0] val;
		if (ovf) begin
			val = neg ? {1'b1, {(RateBits-1){1'b0}}} : {1'b0, {(RateBits-1){1'b1}}};
		end else if (neg) begin
			val = -$signed({1'b0, mag});
		end else begin
			val = $signed({1'b0, mag});
		end
		return val;
	endfunction

endpackage
`default_nettype wire

[rtl/wts_delay.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wts_delay: fixed delay line
// Carries side data alongside the arithmetic pipeline for a set number of
// cycles so that it meets the matching divider output.
// ----------------------------------------------------------------------------
module wts_delay #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  wire logic             clk,
	input  wire logic [Width-1:0] din,
	output logic      [Width-1:0] dout
);

	logic [Width-1:0] taps_q [Depth];

	// shift one stage per cycle
	always_ff @(posedge clk) begin
		taps_q[0] <= din;
		for (int i = 1; i < Depth; i++) begin
			taps_q[i] <= taps_q[i-1];
		end
	end

	assign dout = taps_q[Depth-1];

endmodule
`default_nettype wire

[rtl/wts_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wts_divider: pipelined restoring divider
// One quotient bit per stage, one new operand every cycle. The user must hold
// the divisor steady while work is in flight; unchecked. Flags an overflow.
// ----------------------------------------------------------------------------
module wts_divider #(
	parameter int NumW = 41,
	parameter int QuoW = 9
) (
	input  wire logic                         clk,
	input  wire logic [NumW-1:0]              num,
	input  wire logic [wts_pkg::TimeBits-1:0] den,
	output logic      [QuoW-1:0]              quo,
	output logic      [wts_pkg::TimeBits-1:0] rem,
	output logic                              ovf
);

	localparam int DenW = wts_pkg::TimeBits;
	localparam int HiW  = NumW - QuoW;
	localparam int CmpW = (HiW > DenW) ? HiW : DenW;

	logic [CmpW-1:0] hi_ext;
	logic [DenW-1:0] rem0;
	logic            ovf0;

	logic [DenW-1:0] rem_s  [1:QuoW];
	logic [QuoW-1:0] work_s [1:QuoW];
	logic            ovf_s  [1:QuoW];

	// upper part of the dividend seeds the partial remainder
	assign hi_ext = CmpW'(num[NumW-1:QuoW]);
	assign rem0   = hi_ext[DenW-1:0];
	assign ovf0   = (hi_ext >= CmpW'(den));

	for (genvar i = 1; i <= QuoW; i++) begin : g_stage
		logic [DenW-1:0] src_rem;
		logic [QuoW-1:0] src_work;
		logic            src_ovf;
		logic [DenW:0]   trial;
		logic [DenW:0]   diff;
		logic            take;

		if (i == 1) begin : g_first
			assign src_rem  = rem0;
			assign src_work = num[QuoW-1:0];
			assign src_ovf  = ovf0;
		end else begin : g_next
			assign src_rem  = rem_s[i-1];
			assign src_work = work_s[i-1];
			assign src_ovf  = ovf_s[i-1];
		end

		// trial subtract of the divisor
		assign trial = {src_rem, src_work[QuoW-1]};
		assign diff  = trial - {1'b0, den};
		assign take  = (trial >= {1'b0, den});

		always_ff @(posedge clk) begin
			rem_s[i]  <= take ? diff[DenW-1:0] : trial[DenW-1:0];
			work_s[i] <= {src_work[QuoW-2:0], take};
			ovf_s[i]  <= src_ovf;
		end
	end

	assign quo = work_s[QuoW];
	assign rem = rem_s[QuoW];
	assign ovf = ovf_s[QuoW];

endmodule
`default_nettype wire

[rtl/wts_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wts_table: waypoint memory
// Two banks split by index parity, each with one write and two read ports,
// so the four neighbors k-1..k+2 of a segment come out in one read.
// ----------------------------------------------------------------------------
module wts_table #(
	parameter int AddrW = 8
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [AddrW-1:0]   wr_addr,
	input  wire wts_pkg::wp_t       wr_data,
	input  wire logic [AddrW-1:0]   rd_addr,
	output wts_pkg::taps_t          taps
);

	localparam int BankW = AddrW - 1;
	localparam int Depth = 1 << BankW;

	wts_pkg::wp_t even_mem [Depth];
	wts_pkg::wp_t odd_mem  [Depth];

	logic [AddrW-1:0] idx_p, idx_b, idx_n;
	logic [BankW-1:0] e_addr0, e_addr1, o_addr0, o_addr1;
	logic             odd_k;
	logic             odd_q;
	wts_pkg::wp_t     e0_q, e1_q, o0_q, o1_q;

	// neighbor addresses and bank steering
	always_comb begin
		idx_p   = rd_addr - AddrW'(1);
		idx_b   = rd_addr + AddrW'(1);
		idx_n   = rd_addr + AddrW'(2);
		odd_k   = rd_addr[0];
		e_addr0 = odd_k ? idx_p[AddrW-1:1]   : rd_addr[AddrW-1:1];
		e_addr1 = odd_k ? idx_b[AddrW-1:1]   : idx_n[AddrW-1:1];
		o_addr0 = odd_k ? rd_addr[AddrW-1:1] : idx_p[AddrW-1:1];
		o_addr1 = odd_k ? idx_n[AddrW-1:1]   : idx_b[AddrW-1:1];
	end

	// even bank
	always_ff @(posedge clk) begin
		if (wr_en && !wr_addr[0]) begin
			even_mem[wr_addr[AddrW-1:1]] <= wr_data;
		end
		e0_q <= even_mem[e_addr0];
		e1_q <= even_mem[e_addr1];
	end

	// odd bank
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr[0]) begin
			odd_mem[wr_addr[AddrW-1:1]] <= wr_data;
		end
		o0_q  <= odd_mem[o_addr0];
		o1_q  <= odd_mem[o_addr1];
		odd_q <= odd_k;
	end

	// put the words back in index order
	always_comb begin
		if (odd_q) begin
			taps.prev = e0_q;
			taps.a    = o0_q;
			taps.b    = e1_q;
			taps.next = o1_q;
		end else begin
			taps.prev = o0_q;
			taps.a    = e0_q;
			taps.b    = o1_q;
			taps.next = e1_q;
		end
	end

endmodule
`default_nettype wire

[rtl/waypoint_trajectory_sampler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_trajectory_sampler_top: trajectory sampler over a waypoint table
// Loads write waypoints; queries return interpolated position, segment
// velocity and finite difference acceleration in fixed point.
//
//   port group         dir   handshake
//   item               in    transfer when start is high and busy is low
//   result             out   transfer in the cycle that done is high
//   cfg_index/data     in    transfer when cfg_we is high
//
// One item is taken every cycle; busy stays low. Every item gives one result,
// in order. The acceleration path is the longest: the segment divider, then
// pipelined dividers of 59 and 47 stages in series, one quotient bit per stage.
// Table entries hold nothing after reset until written; no clearing pass.
// Results cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module waypoint_trajectory_sampler_top #(
	parameter int MAX_POINTS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire wts_pkg::item_t              item,
	output logic                             done,
	output wts_pkg::result_t                 result,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [wts_pkg::CfgBits-1:0] cfg_data
);

	localparam int CB    = wts_pkg::CoordBits;
	localparam int TB    = wts_pkg::TimeBits;
	localparam int NB    = wts_pkg::CountBits;
	localparam int FB    = wts_pkg::FracBits;
	localparam int RB    = wts_pkg::RateBits;
	localparam int AddrW = ($clog2(MAX_POINTS) < 2) ? 2 : $clog2(MAX_POINTS);

	// operand widths
	localparam int UW    = TB + NB;
	localparam int RNW   = TB + FB;
	localparam int VMagW = CB + 1 + NB;
	localparam int AMagW = CB + 2 + NB;
	localparam int VNW   = VMagW + FB;
	localparam int Q1W   = AMagW + FB;
	localparam int ANW1  = Q1W + 1;
	localparam int P2W   = Q1W + NB;
	localparam int ANW2  = P2W + FB;
	localparam int RQW   = RB - 1;
	localparam int PW    = CB + FB + 2;

	// stage numbers
	localparam int S_K   = 1 + NB;
	localparam int S_F   = S_K + FB;
	localparam int S_D   = S_K + 2;
	localparam int S_DV  = S_D + 1;
	localparam int S_VEL = S_DV + RQW;
	localparam int S_Q1  = S_DV + Q1W;
	localparam int S_ACC = S_Q1 + 1 + RQW;
	localparam int S_POS = S_F + 1;
	localparam int S_OUT = S_ACC + 1;

	typedef struct packed {
		logic                 func;
		logic [wts_pkg::IndexBits-1:0] idx;
		wts_pkg::wp_t         pt;
		logic                 zero;
		logic                 late;
		logic                 endt;
	} side_t;

	typedef struct packed {
		logic func;
		logic late;
		logic special;
		logic half;
		logic first;
		logic last;
	} ctl11_t;

	typedef struct packed {
		logic func;
		logic late;
		logic special;
		logic esx;
		logic esy;
	} ctl12_t;

	typedef struct packed {
		logic signed [CB-1:0] ax;
		logic signed [CB-1:0] ay;
		logic signed [CB:0]   dx;
		logic signed [CB:0]   dy;
		logic                 special;
	} posln_t;

	typedef struct packed {
		logic signed [RB-1:0] vx;
		logic signed [RB-1:0] vy;
	} vel_t;

	typedef struct packed {
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
	} pos_t;

	// ------------------------------------------------------------------
	// helpers
	function automatic logic signed [CB:0] wide_diff(
		input logic signed [CB-1:0] hi,
		input logic signed [CB-1:0] lo
	);
		return {hi[CB-1], hi} - {lo[CB-1], lo};
	endfunction

	function automatic logic signed [CB+1:0] curv(
		input logic half, input logic first, input logic last,
		input logic signed [CB-1:0] p, input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b, input logic signed [CB-1:0] n
	);
		logic signed [CB+1:0] d_ab, d_pa, d_bn, e;
		d_ab = (CB+2)'(wide_diff(b, a));
		d_pa = (CB+2)'(wide_diff(a, p));
		d_bn = (CB+2)'(wide_diff(n, b));
		if (half) begin
			e = first ? d_ab : d_ab - d_pa;
		end else begin
			e = last ? -d_ab : d_bn - d_ab;
		end
		return e;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	logic [TB-1:0] total_time_q;
	logic [NB-1:0] point_count_q;
	logic [NB-1:0] cnt_n, nm1, nm2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q  <= TB'(65536);
			point_count_q <= NB'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				wts_pkg::RegTotalTime:  total_time_q  <= cfg_data[TB-1:0];
				wts_pkg::RegPointCount: point_count_q <= cfg_data[NB-1:0];
				default: ;
			endcase
		end
	end

	// clamp the point count to the table
	always_comb begin
		if (point_count_q < NB'(2)) begin
			cnt_n = NB'(2);
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			cnt_n = NB'(MAX_POINTS);
		end else begin
			cnt_n = point_count_q;
		end
		nm1 = cnt_n - NB'(1);
		nm2 = cnt_n - NB'(2);
	end

	// ------------------------------------------------------------------
	// input transfer and valid tracking
	logic             accept;
	logic [S_OUT:1]   vld_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[S_OUT-1:1], accept};
		end
	end

	// stage 1: time checks and segment numerator
	side_t          side_s1;
	logic [UW-1:0]  u_s1;

	always_ff @(posedge clk) begin
		side_s1.func <= item.func;
		side_s1.idx  <= item.point_index;
		side_s1.pt.x <= item.point_x;
		side_s1.pt.y <= item.point_y;
		side_s1.zero <= (item.query_time == '0);
		side_s1.late <= (item.query_time > total_time_q);
		side_s1.endt <= (item.query_time == total_time_q);
		u_s1         <= UW'(item.query_time) * UW'(nm1);
	end

	// segment index and remainder
	logic [NB-1:0] k_s10;
	logic [TB-1:0] r_s10;
	logic          kovf_s10;
	side_t         side_s10;

	wts_divider #(.NumW(UW), .QuoW(NB)) u_div_seg (
		.clk (clk),
		.num (u_s1),
		.den (total_time_q),
		.quo (k_s10),
		.rem (r_s10),
		.ovf (kovf_s10)
	);

	wts_delay #(.Width($bits(side_t)), .Depth(S_K - 1)) u_dly_side (
		.clk  (clk),
		.din  (side_s1),
		.dout (side_s10)
	);

	// stage 10: table access, loads write here in item order
	logic [NB-1:0]     k_eff;
	logic              tbl_we;
	wts_pkg::taps_t    taps_s11;
	ctl11_t            ctl_s11;

	always_comb begin
		if (side_s10.zero) begin
			k_eff = '0;
		end else if (side_s10.endt) begin
			k_eff = nm1;
		end else if (kovf_s10 || k_s10 > nm2) begin
			k_eff = nm2;
		end else begin
			k_eff = k_s10;
		end
		tbl_we = vld_q[S_K] && (side_s10.func == wts_pkg::FuncWrite) &&
		         (32'(side_s10.idx) < 32'(MAX_POINTS));
	end

	wts_table #(.AddrW(AddrW)) u_table (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (AddrW'(side_s10.idx)),
		.wr_data (side_s10.pt),
		.rd_addr (AddrW'(k_eff)),
		.taps    (taps_s11)
	);

	always_ff @(posedge clk) begin
		ctl_s11.func    <= side_s10.func;
		ctl_s11.late    <= side_s10.late && !side_s10.zero;
		ctl_s11.special <= side_s10.zero || side_s10.endt;
		ctl_s11.half    <= ({r_s10, 1'b0} < {1'b0, total_time_q});
		ctl_s11.first   <= (k_eff == '0);
		ctl_s11.last    <= (k_eff == nm2);
	end

	// interpolant f from the remainder
	logic [FB-1:0] f_s26;
	logic [TB-1:0] frem_unused;
	logic          fovf_unused;

	wts_divider #(.NumW(RNW), .QuoW(FB)) u_div_frac (
		.clk (clk),
		.num ({r_s10, {FB{1'b0}}}),
		.den (total_time_q),
		.quo (f_s26),
		.rem (frem_unused),
		.ovf (fovf_unused)
	);

	// stage 11: segment differences
	posln_t                pl_s12;
	logic signed [CB+1:0]  ex_c, ey_c;
	logic signed [CB+1:0]  ex_s12, ey_s12;
	ctl12_t                ctl_s12;

	always_comb begin
		ex_c = curv(ctl_s11.half, ctl_s11.first, ctl_s11.last, taps_s11.prev.x,
		            taps_s11.a.x, taps_s11.b.x, taps_s11.next.x);
		ey_c = curv(ctl_s11.half, ctl_s11.first, ctl_s11.last, taps_s11.prev.y,
		            taps_s11.a.y, taps_s11.b.y, taps_s11.next.y);
	end

	// ends of the trajectory take waypoint a as is, so no slope there
	always_ff @(posedge clk) begin
		pl_s12.ax      <= taps_s11.a.x;
		pl_s12.ay      <= taps_s11.a.y;
		pl_s12.dx      <= ctl_s11.special ? '0 : wide_diff(taps_s11.b.x, taps_s11.a.x);
		pl_s12.dy      <= ctl_s11.special ? '0 : wide_diff(taps_s11.b.y, taps_s11.a.y);
		pl_s12.special <= ctl_s11.special;
		ex_s12 <= ex_c;
		ey_s12 <= ey_c;
		ctl_s12.func    <= ctl_s11.func;
		ctl_s12.late    <= ctl_s11.late;
		ctl_s12.special <= ctl_s11.special;
		ctl_s12.esx     <= ex_c[CB+1];
		ctl_s12.esy     <= ey_c[CB+1];
	end

	// stage 12: magnitudes scaled by the segment count
	logic [CB:0]     mdx, mdy;
	logic [CB+1:0]   mex, mey;
	logic [VNW-1:0]  vnx_s13, vny_s13;
	logic [ANW1-1:0] anx_s13, any_s13;

	always_comb begin
		mdx = pl_s12.dx[CB] ? (CB+1)'(-pl_s12.dx) : (CB+1)'(pl_s12.dx);
		mdy = pl_s12.dy[CB] ? (CB+1)'(-pl_s12.dy) : (CB+1)'(pl_s12.dy);
		mex = ex_s12[CB+1]  ? (CB+2)'(-ex_s12)    : (CB+2)'(ex_s12);
		mey = ey_s12[CB+1]  ? (CB+2)'(-ey_s12)    : (CB+2)'(ey_s12);
	end

	always_ff @(posedge clk) begin
		vnx_s13 <= {VMagW'(mdx) * VMagW'(nm1), {FB{1'b0}}};
		vny_s13 <= {VMagW'(mdy) * VMagW'(nm1), {FB{1'b0}}};
		anx_s13 <= {1'b0, AMagW'(mex) * AMagW'(nm1), {FB{1'b0}}};
		any_s13 <= {1'b0, AMagW'(mey) * AMagW'(nm1), {FB{1'b0}}};
	end

	// position: interpolate once f is ready
	posln_t               pl_s26;
	logic [FB-1:0]        f_use;
	logic signed [PW-1:0] prx_s27, pry_s27;
	logic signed [CB-1:0] ax_s27, ay_s27;
	logic signed [PW-1:0] shx, shy;
	pos_t                 pos_s27, pos_s120;

	wts_delay #(.Width($bits(posln_t)), .Depth(S_F - S_D)) u_dly_pos (
		.clk  (clk),
		.din  (pl_s12),
		.dout (pl_s26)
	);

	assign f_use = pl_s26.special ? '0 : f_s26;

	always_ff @(posedge clk) begin
		prx_s27 <= PW'(pl_s26.dx) * PW'($signed({1'b0, f_use}));
		pry_s27 <= PW'(pl_s26.dy) * PW'($signed({1'b0, f_use}));
		ax_s27  <= pl_s26.ax;
		ay_s27  <= pl_s26.ay;
	end

	always_comb begin
		shx        = prx_s27 >>> FB;
		shy        = pry_s27 >>> FB;
		pos_s27.px = ax_s27 + $signed(shx[CB-1:0]);
		pos_s27.py = ay_s27 + $signed(shy[CB-1:0]);
	end

	wts_delay #(.Width($bits(pos_t)), .Depth(S_ACC - S_POS)) u_dly_posout (
		.clk  (clk),
		.din  (pos_s27),
		.dout (pos_s120)
	);

	// velocity
	logic [RQW-1:0] vqx, vqy;
	logic [TB-1:0]  vrx_unused, vry_unused;
	logic           vox, voy;
	logic [1:0]     vsgn_s60;
	vel_t           vel_s60, vel_s120;

	wts_divider #(.NumW(VNW), .QuoW(RQW)) u_div_vx (
		.clk (clk), .num (vnx_s13), .den (total_time_q),
		.quo (vqx), .rem (vrx_unused), .ovf (vox)
	);

	wts_divider #(.NumW(VNW), .QuoW(RQW)) u_div_vy (
		.clk (clk), .num (vny_s13), .den (total_time_q),
		.quo (vqy), .rem (vry_unused), .ovf (voy)
	);

	wts_delay #(.Width(2), .Depth(S_VEL - S_D)) u_dly_vsgn (
		.clk  (clk),
		.din  ({pl_s12.dx[CB], pl_s12.dy[CB]}),
		.dout (vsgn_s60)
	);

	assign vel_s60.vx = wts_pkg::sat_rate(vsgn_s60[1], vox, vqx);
	assign vel_s60.vy = wts_pkg::sat_rate(vsgn_s60[0], voy, vqy);

	wts_delay #(.Width($bits(vel_t)), .Depth(S_ACC - S_VEL)) u_dly_vel (
		.clk  (clk),
		.din  (vel_s60),
		.dout (vel_s120)
	);

	// acceleration: two successive divisions by the duration
	logic [Q1W-1:0]  q1x, q1y;
	logic [TB-1:0]   a1rx_unused, a1ry_unused, a2rx_unused, a2ry_unused;
	logic            a1ox_unused, a1oy_unused;
	logic [ANW2-1:0] a2x_s73, a2y_s73;
	logic [RQW-1:0]  aqx, aqy;
	logic            aox, aoy;

	wts_divider #(.NumW(ANW1), .QuoW(Q1W)) u_div_a1x (
		.clk (clk), .num (anx_s13), .den (total_time_q),
		.quo (q1x), .rem (a1rx_unused), .ovf (a1ox_unused)
	);

	wts_divider #(.NumW(ANW1), .QuoW(Q1W)) u_div_a1y (
		.clk (clk), .num (any_s13), .den (total_time_q),
		.quo (q1y), .rem (a1ry_unused), .ovf (a1oy_unused)
	);

	always_ff @(posedge clk) begin
		a2x_s73 <= {P2W'(q1x) * P2W'(nm1), {FB{1'b0}}};
		a2y_s73 <= {P2W'(q1y) * P2W'(nm1), {FB{1'b0}}};
	end

	wts_divider #(.NumW(ANW2), .QuoW(RQW)) u_div_a2x (
		.clk (clk), .num (a2x_s73), .den (total_time_q),
		.quo (aqx), .rem (a2rx_unused), .ovf (aox)
	);

	wts_divider #(.NumW(ANW2), .QuoW(RQW)) u_div_a2y (
		.clk (clk), .num (a2y_s73), .den (total_time_q),
		.quo (aqy), .rem (a2ry_unused), .ovf (aoy)
	);

	// control for the final stage
	ctl12_t ctl_s120;

	wts_delay #(.Width($bits(ctl12_t)), .Depth(S_ACC - S_D)) u_dly_ctl (
		.clk  (clk),
		.din  (ctl_s12),
		.dout (ctl_s120)
	);

	// result assembly and output register
	wts_pkg::result_t res_c;
	wts_pkg::result_t result_q;

	always_comb begin
		res_c = '0;
		if (ctl_s120.func == wts_pkg::FuncWrite) begin
			res_c.status = wts_pkg::StatusWrite;
		end else if (ctl_s120.late) begin
			res_c.status = wts_pkg::StatusRange;
		end else begin
			res_c.status = wts_pkg::StatusOk;
			res_c.pos_x  = pos_s120.px;
			res_c.pos_y  = pos_s120.py;
			if (!ctl_s120.special) begin
				res_c.vel_x = vel_s120.vx;
				res_c.vel_y = vel_s120.vy;
				res_c.acc_x = wts_pkg::sat_rate(ctl_s120.esx, aox, aqx);
				res_c.acc_y = wts_pkg::sat_rate(ctl_s120.esy, aoy, aqy);
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign result = result_q;
	assign done   = vld_q[S_OUT];

endmodule
`default_nettype wire

[test/waypoint_trajectory_sampler_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint_trajectory_sampler_checker: result checker for the sampler
// Watches item, configuration and result transfers, predicts each result
// from its own copy of the waypoint table and registers, and compares every
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module waypoint_trajectory_sampler_checker
	import wts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire item_t              item,
	input  wire logic               done,
	input  wire result_t            result,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CfgBits-1:0] cfg_data,
	output int                      fail_count,
	output int                      pending
);

	localparam int TableDepth = 256;
	localparam int DueDepth   = 256;

	logic [TimeBits-1:0]  span_time;
	logic [CountBits-1:0] waypoint_num;
	longint               tbl_x [TableDepth];
	longint               tbl_y [TableDepth];
	result_t              due_mem [DueDepth];
	int                   due_wr = 0;
	int                   due_rd = 0;

	assign pending = due_wr - due_rd;

	// floor(a*b/d), capped at 2^63
	function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
			logic [63:0] d);
		logic [127:0] q;
		q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
		if (q >= 128'h8000_0000_0000_0000)
			return 64'h8000_0000_0000_0000;
		return q[63:0];
	endfunction

	// signed 48 bit saturation from sign and magnitude
	function automatic logic [RateBits-1:0] clamp_rate(bit neg, logic [63:0] mag);
		logic [63:0] lim;
		lim = 64'd1 << (RateBits - 1);
		if (neg) begin
			if (mag >= lim)
				return lim[RateBits-1:0];
			return RateBits'(64'd0 - mag);
		end
		if (mag >= lim - 1)
			return RateBits'(lim - 1);
		return mag[RateBits-1:0];
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [CoordBits-1:0] lerp_coord(longint a, longint d,
			longint f);
		longint p;
		p = a + ((d * f) >>> FracBits);
		return p[CoordBits-1:0];
	endfunction

	// expected result of one item against the current table and registers
	function automatic result_t sample_trajectory(item_t it);
		result_t     res;
		logic [63:0] t, tt, n, u, k, r, f, scale, pp, nn;
		longint      ax, ay, bx, by, dx, dy, ex, ey;
		res = '0;
		if (it.func == FuncWrite) begin
			res.status = StatusWrite;
			return res;
		end
		t = 64'(it.query_time);
		tt = 64'(span_time);
		n = 64'(waypoint_num);
		if (n < 2) n = 2;
		if (n > TableDepth) n = TableDepth;
		res.status = StatusOk;
		if (t == 0) begin
			res.pos_x = tbl_x[0][CoordBits-1:0];
			res.pos_y = tbl_y[0][CoordBits-1:0];
			return res;
		end
		if (t > tt) begin
			res.status = StatusRange;
			return res;
		end
		if (t == tt) begin
			res.pos_x = tbl_x[n-1][CoordBits-1:0];
			res.pos_y = tbl_y[n-1][CoordBits-1:0];
			return res;
		end
		u = t * (n - 1);
		k = u / tt;
		r = u % tt;
		if (k > n - 2) k = n - 2;
		f = (r << FracBits) / tt;
		scale = (n - 1) << FracBits;
		ax = tbl_x[k]; ay = tbl_y[k];
		bx = tbl_x[k+1]; by = tbl_y[k+1];
		dx = bx - ax; dy = by - ay;
		res.pos_x = lerp_coord(ax, dx, longint'(f));
		res.pos_y = lerp_coord(ay, dy, longint'(f));
		res.vel_x = clamp_rate(dx < 0, scaled_quot(magnitude(dx), scale, tt));
		res.vel_y = clamp_rate(dy < 0, scaled_quot(magnitude(dy), scale, tt));
		// first half looks back, second half looks ahead
		if (2 * r < tt) begin
			pp = (k > 0) ? k - 1 : 0;
			ex = dx - (ax - tbl_x[pp]);
			ey = dy - (ay - tbl_y[pp]);
		end else begin
			nn = (k + 2 < n - 1) ? k + 2 : n - 1;
			ex = (tbl_x[nn] - bx) - dx;
			ey = (tbl_y[nn] - by) - dy;
		end
		res.acc_x = clamp_rate(ex < 0,
			scaled_quot(scaled_quot(magnitude(ex), scale, tt), scale, tt));
		res.acc_y = clamp_rate(ey < 0,
			scaled_quot(scaled_quot(magnitude(ey), scale, tt), scale, tt));
		return res;
	endfunction

	// predict on item transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			span_time <= 32'd65536;
			waypoint_num <= 9'd2;
			due_wr = 0;
			due_rd = 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegTotalTime)
					span_time <= cfg_data[TimeBits-1:0];
				else
					waypoint_num <= cfg_data[CountBits-1:0];
			end
			if (start && !busy) begin
				due_mem[due_wr % DueDepth] = sample_trajectory(item);
				due_wr = due_wr + 1;
				if (item.func == FuncWrite) begin
					tbl_x[item.point_index] <= longint'(item.point_x);
					tbl_y[item.point_index] <= longint'(item.point_y);
				end
			end
			if (done) begin
				if (due_wr == due_rd) begin
					$error("result transfer with no result expected");
					fail_count <= fail_count + 1;
				end else begin
					want = due_mem[due_rd % DueDepth];
					due_rd = due_rd + 1;
					if (want !== result) begin
						fail_count <= fail_count + 1;
						if (want.status !== result.status)
							$error("status: expected %0d, got %0d", want.status,
								result.status);
						if (want.pos_x !== result.pos_x)
							$error("pos_x: expected %0d, got %0d", want.pos_x,
								result.pos_x);
						if (want.pos_y !== result.pos_y)
							$error("pos_y: expected %0d, got %0d", want.pos_y,
								result.pos_y);
						if (want.vel_x !== result.vel_x)
							$error("vel_x: expected %0d, got %0d", want.vel_x,
								result.vel_x);
						if (want.vel_y !== result.vel_y)
							$error("vel_y: expected %0d, got %0d", want.vel_y,
								result.vel_y);
						if (want.acc_x !== result.acc_x)
							$error("acc_x: expected %0d, got %0d", want.acc_x,
								result.acc_x);
						if (want.acc_y !== result.acc_y)
							$error("acc_y: expected %0d, got %0d", want.acc_y,
								result.acc_y);
					end
				end
			end
		end
	end

endmodule

[test/waypoint_trajectory_sampler_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint_trajectory_sampler_top_tb: testbench of the trajectory sampler
// Runs several register settings (extremes included), each with waypoint
// loads and queries at ends, out of range, segment edges and random times,
// under varying input gaps. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module waypoint_trajectory_sampler_top_tb;
	import wts_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 140;
	localparam int PhaseCount = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	item_t              item = '0;
	logic               done;
	result_t            result;
	logic               cfg_we = 1'b0;
	logic               cfg_index = RegTotalTime;
	logic [CfgBits-1:0] cfg_data = '0;
	int                 fail_count;
	int                 pending;
	int                 cycle_count = 0;
	int                 gap_pct = 0;
	logic [31:0]        cur_span = 32'd65536;
	int                 cur_count = 2;
	bit                 written [256];

	waypoint_trajectory_sampler_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	waypoint_trajectory_sampler_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// random idle cycles, then one item transfer
	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) begin
			@(negedge clk);
			@(posedge clk);
		end
		@(negedge clk);
		if (it.func == FuncWrite)
			written[it.point_index] = 1'b1;
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 65535 * 4)) - 131070);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_load(input int idx);
		item_t it;
		it = '0;
		it.func = FuncWrite;
		it.point_index = idx[7:0];
		it.point_x = pick_coord();
		it.point_y = pick_coord();
		it.query_time = $urandom;
		send_item(it);
	endtask

	task automatic send_query(input logic [31:0] t);
		item_t it;
		it.func = FuncQuery;
		it.point_index = IndexBits'($urandom);
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.query_time = t;
		send_item(it);
	endtask

	// query time: ends, out of range, segment edges or anywhere inside
	function automatic logic [31:0] pick_time();
		longint unsigned span, seg;
		span = longint'(cur_span);
		case ($urandom_range(0, 11))
			0: return 32'd0;
			1: return cur_span;
			2: return (span < 64'hFFFF_FFFF) ? 32'(span + 1) : cur_span;
			3: return (span < 64'hFFFF_FFFF) ?
				32'(span + 1 + {$urandom} % (64'hFFFF_FFFF - span)) : 32'hFFFF_FFFF;
			4, 5: begin
				seg = $urandom_range(0, cur_count - 1);
				seg = (seg * span) / (cur_count - 1) + $urandom_range(0, 2);
				return (seg > 0 && seg > span) ? cur_span : 32'(seg - (seg > 0));
			end
			default: return 32'({$urandom} % (span + 1));
		endcase
	endfunction

	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CfgBits-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] spans [PhaseCount];
		int          counts [PhaseCount];
		int          gaps [3];
		spans = '{32'd65536, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd0, 32'd1000};
		counts = '{2, 2, 256, 256, 0, 17};
		gaps = '{0, 57, 17};
		spans[4] = $urandom_range(2, 32'h7FFF_FFFF);
		counts[4] = $urandom_range(2, 256);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PhaseCount; p++) begin
			gap_pct = gaps[p % 3];
			cur_span = spans[p];
			cur_count = counts[p];
			write_reg(RegTotalTime, spans[p]);
			write_reg(RegPointCount, CfgBits'(counts[p]));
			// every waypoint in use is loaded before any query
			for (int i = 0; i < cur_count; i++)
				if (!written[i]) send_load(i);
			if (p == 0) begin
				send_load(0);
				send_load(1);
				send_load(255);
				send_query(32'd0);
				send_query(cur_span);
				send_query(cur_span + 1);
				send_query(32'hFFFF_FFFF);
				send_query(32'd1);
				send_query(cur_span - 1);
				send_query(cur_span >> 1);
				send_query((cur_span >> 1) - 1);
				send_query(cur_span >> 2);
				send_query(cur_span - (cur_span >> 2));
			end
			for (int j = 0; j < 105; j++) begin
				if ($urandom_range(0, 3) == 0)
					send_load($urandom_range(0, 255));
				else
					send_query(pick_time());
			end
			wait_idle();
		end

		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
